// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expands to one labeled concurrent assertion that is clocked on
// the rising edge and held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define DDM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define DDM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: sv/ddm_pkg.sv
package ddm_pkg;

	// Full-scale axis magnitude; larger magnitudes saturate to it.
	localparam int AXIS_FULL_SCALE = 512;
	localparam int AXIS_SHIFT      = $clog2(AXIS_FULL_SCALE);

	localparam int AXIS_W  = 11;
	localparam int MAG_W   = AXIS_SHIFT + 1;
	localparam int DUTY_W  = 8;
	localparam int GAIN_W  = 10;
	localparam int GAIN_FRAC = 8;
	localparam int LINES_W = 4;

	localparam int MUL_W  = (MAG_W > GAIN_W) ? MAG_W : GAIN_W;
	localparam int PROD_W = 2 * MUL_W;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [DUTY_W-1:0]  DUTY_MAX   = '1;
	localparam logic [DUTY_W-1:0]  MIN_SPEED_RESET = '0;
	localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(256);

	localparam logic [LINES_W-1:0] LINES_BRAKE       = 4'h0;
	localparam logic [LINES_W-1:0] LINES_FORWARD     = 4'hA;
	localparam logic [LINES_W-1:0] LINES_BACKWARD    = 4'h5;
	localparam logic [LINES_W-1:0] LINES_PIVOT_RIGHT = 4'h6;
	localparam logic [LINES_W-1:0] LINES_PIVOT_LEFT  = 4'h9;

	typedef enum logic [1:0] {
		REG_MIN_SPEED  = 2'd0,
		REG_LEFT_GAIN  = 2'd1,
		REG_RIGHT_GAIN = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DUTY_W-1:0] min_speed;
		logic [GAIN_W-1:0] left_gain;
		logic [GAIN_W-1:0] right_gain;
	} cfg_t;

	// Absolute value of a signed axis reading, saturated to full scale.
	function automatic logic [MAG_W-1:0] axis_mag(input logic signed [AXIS_W-1:0] v);
		logic [AXIS_W-1:0] a;
		begin
			a = v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
			if (a > AXIS_W'(AXIS_FULL_SCALE)) begin
				return MAG_W'(AXIS_FULL_SCALE);
			end
			return MAG_W'(a);
		end
	endfunction

endpackage

// File: sv/ddm_cmd_if.sv
interface ddm_cmd_if;
	import ddm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     command;
	logic signed [AXIS_W-1:0] first_axis;
	logic signed [AXIS_W-1:0] second_axis;
	logic                     curve_enable;

	modport source (output valid, command, first_axis, second_axis, curve_enable,
		input ready);
	modport sink (input valid, command, first_axis, second_axis, curve_enable,
		output ready);
endinterface

// File: sv/ddm_res_if.sv
interface ddm_res_if;
	import ddm_pkg::*;

	logic               valid;
	logic               ready;
	logic [DUTY_W-1:0]  left_duty;
	logic [DUTY_W-1:0]  right_duty;
	logic [LINES_W-1:0] bridge_lines;
	logic               braked;

	modport source (output valid, left_duty, right_duty, bridge_lines, braked,
		input ready);
	modport sink (input valid, left_duty, right_duty, bridge_lines, braked,
		output ready);
endinterface

// File: sv/ddm_apb_regs.sv
module ddm_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ddm_pkg::ADDR_W-1:0] paddr,
	input  logic [ddm_pkg::DATA_W-1:0] pwdata,
	output logic [ddm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output ddm_pkg::cfg_t              cfg
);
	import ddm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_speed  <= MIN_SPEED_RESET;
			cfg_q.left_gain  <= GAIN_RESET;
			cfg_q.right_gain <= GAIN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_SPEED:  cfg_q.min_speed  <= pwdata[DUTY_W-1:0];
				REG_LEFT_GAIN:  cfg_q.left_gain  <= pwdata[GAIN_W-1:0];
				REG_RIGHT_GAIN: cfg_q.right_gain <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MIN_SPEED:  prdata = DATA_W'(cfg_q.min_speed);
			REG_LEFT_GAIN:  prdata = DATA_W'(cfg_q.left_gain);
			REG_RIGHT_GAIN: prdata = DATA_W'(cfg_q.right_gain);
			default:        prdata = '0;
		endcase
	end
endmodule

// File: sv/differential_drive_mixer_core.sv
// Channel  Dir  Handshake      Request contents
// cmd      in   valid / ready  command, first_axis, second_axis, curve_enable
// res      out  valid / ready  left_duty, right_duty, bridge_lines, braked
// apb      in   psel/penable   min_speed, left_gain, right_gain at 0x0, 0x4, 0x8
//
// A curved arcade mix runs S_CURVE_A, S_CURVE_B, S_MAP_A, S_REDUCE, S_SCALE_L,
// S_SCALE_R and S_DONE; an uncurved one starts at S_MAP_A, a pivot uses S_MAP_B for
// S_REDUCE, and a brake leaves S_MAP_A for S_DONE. The result turns valid at handover
// from S_DONE; S_IDLE takes the next request. One shared multiplier does each product.
// cmd.ready is high only while the sequencer is idle; a finished result sits in
// the output register, so a new request is taken while res is stalled. If the output
// register is still full when the next result is done, the sequencer waits for it.
// Reset clears the sequencer, the output valid and the bridge state to all low.
module differential_drive_mixer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	ddm_cmd_if.sink                    cmd,
	ddm_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ddm_pkg::ADDR_W-1:0] paddr,
	input  logic [ddm_pkg::DATA_W-1:0] pwdata,
	output logic [ddm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import ddm_pkg::*;

	// The sequencer walks through one multiply per state. Pivot requests skip
	// the curve and the steering reduction and map the second axis instead.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CURVE_A,
		S_CURVE_B,
		S_MAP_A,
		S_MAP_B,
		S_REDUCE,
		S_SCALE_L,
		S_SCALE_R,
		S_DONE
	} state_t;

	cfg_t cfg;

	ddm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t             state_q;
	logic               pivot_q;
	logic [MAG_W-1:0]   mag_a_q;
	logic [MAG_W-1:0]   mag_b_q;
	logic               neg_a_q;
	logic               neg_b_q;
	logic [DUTY_W-1:0]  spd_a_q;
	logic [DUTY_W-1:0]  spd_b_q;
	logic [DUTY_W-1:0]  left_q;
	logic [DUTY_W-1:0]  right_q;
	logic               brk_q;
	logic [LINES_W-1:0] bridge_q;

	logic               res_valid_q;
	logic [DUTY_W-1:0]  res_left_q;
	logic [DUTY_W-1:0]  res_right_q;
	logic [LINES_W-1:0] res_lines_q;
	logic               res_brk_q;

	logic                   accept;
	logic                   handover;
	logic                   b_pos;
	logic                   swap;
	logic                   brake_now;
	logic [DUTY_W-1:0]      speed_l;
	logic [DUTY_W-1:0]      speed_r;
	logic [MUL_W-1:0]       op_a;
	logic [MUL_W-1:0]       op_b;
	logic [PROD_W-1:0]      prod;
	logic [PROD_W-AXIS_SHIFT-1:0] prod_sh;
	logic [PROD_W-GAIN_FRAC-1:0]  prod_gain;
	logic [DUTY_W:0]        map_sum;
	logic [DUTY_W-1:0]      map_val;
	logic [DUTY_W-1:0]      reduce_val;
	logic [DUTY_W-1:0]      clamp_val;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);

	// Hand over only when the output register is free or being read.
	assign handover = (state_q == S_DONE) && (!res_valid_q || res.ready);

	// Steering to the right lowers the right wheel; zero steering counts as a
	// left turn, which leaves both wheels at the mapped speed anyway.
	assign b_pos   = !neg_b_q && (mag_b_q != '0);
	assign swap    = !pivot_q && !b_pos;
	assign speed_l = swap ? spd_b_q : spd_a_q;
	assign speed_r = swap ? spd_a_q : spd_b_q;

	// An arcade request brakes on zero throttle after the curve; a pivot
	// request brakes only when both throttles are zero.
	assign brake_now = (mag_a_q == '0) && (!pivot_q || (mag_b_q == '0));

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_CURVE_A: begin
				op_a = MUL_W'(mag_a_q);
				op_b = MUL_W'(mag_a_q);
			end
			S_CURVE_B: begin
				op_a = MUL_W'(mag_b_q);
				op_b = MUL_W'(mag_b_q);
			end
			S_MAP_A: begin
				op_a = MUL_W'(mag_a_q);
				op_b = MUL_W'(DUTY_MAX - cfg.min_speed);
			end
			S_MAP_B: begin
				op_a = MUL_W'(mag_b_q);
				op_b = MUL_W'(DUTY_MAX - cfg.min_speed);
			end
			S_REDUCE: begin
				op_a = MUL_W'(mag_b_q);
				op_b = MUL_W'(spd_a_q - cfg.min_speed);
			end
			S_SCALE_L: begin
				op_a = MUL_W'(speed_l);
				op_b = MUL_W'(cfg.left_gain);
			end
			S_SCALE_R: begin
				op_a = MUL_W'(speed_r);
				op_b = MUL_W'(cfg.right_gain);
			end
			default: ;
		endcase
	end

	assign prod      = op_a * op_b;
	assign prod_sh   = prod[PROD_W-1:AXIS_SHIFT];
	assign prod_gain = prod[PROD_W-1:GAIN_FRAC];

	// The mapped speed never exceeds full duty, so the carry is always clear.
	assign map_sum    = {1'b0, prod_sh[DUTY_W-1:0]} + {1'b0, cfg.min_speed};
	assign map_val    = map_sum[DUTY_W-1:0];
	assign reduce_val = spd_a_q - prod_sh[DUTY_W-1:0];

	// Gain-scaled speed, raised to min_speed and then capped at full duty.
	always_comb begin
		priority if (prod_gain < (PROD_W-GAIN_FRAC)'(cfg.min_speed)) begin
			clamp_val = cfg.min_speed;
		end else if (prod_gain > (PROD_W-GAIN_FRAC)'(DUTY_MAX)) begin
			clamp_val = DUTY_MAX;
		end else begin
			clamp_val = prod_gain[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pivot_q     <= 1'b0;
			mag_a_q     <= '0;
			mag_b_q     <= '0;
			neg_a_q     <= 1'b0;
			neg_b_q     <= 1'b0;
			spd_a_q     <= '0;
			spd_b_q     <= '0;
			left_q      <= '0;
			right_q     <= '0;
			brk_q       <= 1'b0;
			bridge_q    <= LINES_BRAKE;
			res_valid_q <= 1'b0;
			res_left_q  <= '0;
			res_right_q <= '0;
			res_lines_q <= LINES_BRAKE;
			res_brk_q   <= 1'b0;
		end else begin
			if (handover) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pivot_q <= cmd.command;
						mag_a_q <= axis_mag(cmd.first_axis);
						mag_b_q <= axis_mag(cmd.second_axis);
						neg_a_q <= cmd.first_axis[AXIS_W-1];
						neg_b_q <= cmd.second_axis[AXIS_W-1];
						brk_q   <= 1'b0;
						state_q <= (!cmd.command && cmd.curve_enable) ? S_CURVE_A : S_MAP_A;
					end
				end
				S_CURVE_A: begin
					mag_a_q <= prod_sh[MAG_W-1:0];
					state_q <= S_CURVE_B;
				end
				S_CURVE_B: begin
					mag_b_q <= prod_sh[MAG_W-1:0];
					state_q <= S_MAP_A;
				end
				S_MAP_A: begin
					if (brake_now) begin
						left_q   <= '0;
						right_q  <= '0;
						brk_q    <= 1'b1;
						bridge_q <= LINES_BRAKE;
						state_q  <= S_DONE;
					end else begin
						spd_a_q <= map_val;
						if (!pivot_q) begin
							bridge_q <= neg_a_q ? LINES_BACKWARD : LINES_FORWARD;
							state_q  <= S_REDUCE;
						end else begin
							// Opposite throttles spin in place; anything else keeps
							// the lines that were driven last.
							if (b_pos && neg_a_q && (mag_a_q != '0)) begin
								bridge_q <= LINES_PIVOT_RIGHT;
							end else if (neg_b_q && (mag_b_q != '0) && !neg_a_q
								&& (mag_a_q != '0)) begin
								bridge_q <= LINES_PIVOT_LEFT;
							end
							state_q <= S_MAP_B;
						end
					end
				end
				S_MAP_B: begin
					spd_b_q <= map_val;
					state_q <= S_SCALE_L;
				end
				S_REDUCE: begin
					spd_b_q <= reduce_val;
					state_q <= S_SCALE_L;
				end
				S_SCALE_L: begin
					left_q  <= clamp_val;
					state_q <= S_SCALE_R;
				end
				S_SCALE_R: begin
					right_q <= clamp_val;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (handover) begin
						res_left_q  <= left_q;
						res_right_q <= right_q;
						res_lines_q <= bridge_q;
						res_brk_q   <= brk_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid        = res_valid_q;
	assign res.left_duty    = res_left_q;
	assign res.right_duty   = res_right_q;
	assign res.bridge_lines = res_lines_q;
	assign res.braked       = res_brk_q;
endmodule

// File: sv/ddm_checker.sv
`include "assert_macros.svh"

module ddm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [ddm_pkg::DUTY_W-1:0]  left_duty,
	input logic [ddm_pkg::DUTY_W-1:0]  right_duty,
	input logic [ddm_pkg::LINES_W-1:0] bridge_lines,
	input logic                        braked
);
	import ddm_pkg::*;

	// The block works on one request at a time.
	`DDM_ASSERT(a_busy_after_accept, clk, arst_n, cmd_valid && cmd_ready |=> !cmd_ready, "ready stayed high after a request was taken")

	// Ready only drops because a request was taken.
	`DDM_ASSERT(a_ready_drop, clk, arst_n, $fell(cmd_ready) |-> $past(cmd_valid), "ready dropped without a request")

	// A brake drives no duty and no bridge line.
	`DDM_ASSERT_NEVER(a_brake_quiet, clk, arst_n, res_valid && braked && ((left_duty != '0) || (right_duty != '0) || (bridge_lines != LINES_BRAKE)), "braked result drives the motors")

	// A stalled result holds still.
	`DDM_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(left_duty) && $stable(right_duty) && $stable(bridge_lines) && $stable(braked), "stalled result changed")
endmodule

bind differential_drive_mixer_core ddm_checker u_ddm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.left_duty    (res.left_duty),
	.right_duty   (res.right_duty),
	.bridge_lines (res.bridge_lines),
	.braked       (res.braked)
);
